// ----- hdl/quicksort_lomuto_sorter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quicksort sorter unit
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_LOMUTO_SORTER_UNIT_DEFINES_SVH
`define QUICKSORT_LOMUTO_SORTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define QLS_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("qls assertion failed");

// Next-cycle implication
`define QLS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("qls assertion failed");

`else

`define QLS_ASSERT_IMPL(name, pre, post)
`define QLS_ASSERT_NEXT(name, pre, post)

`endif

`endif

// ----- hdl/qls_pkg.sv -----
// ----------------------------------------------------------------------------
// qls_pkg
// Shared types and constants of the quicksort sorter unit.
// ----------------------------------------------------------------------------
package qls_pkg;

  // Default list capacity
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // Element width
  localparam int unsigned VALUE_W = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    S_LOAD,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_FETCH,
    S_SCAN,
    S_SWAP,
    S_PUSH_LO,
    S_PUSH_HI,
    S_OUT_RD,
    S_OUT_LOAD
  } state_t;

  // Element memory strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

  // Range stack strobes
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  // Range stack status
  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

// ----- hdl/qls_store.sv -----
// ----------------------------------------------------------------------------
// qls_store
// Element memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module qls_store
  import qls_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_ELEMENTS_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk,
  input  mem_ctrl_t                 ctrl,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr_a,
  input  logic [AW-1:0]             raddr_b,
  output logic signed [VALUE_W-1:0] rdata_a,
  output logic signed [VALUE_W-1:0] rdata_b
);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata_a_r;
  logic signed [VALUE_W-1:0] rdata_b_r;

  // Write one element
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two elements; hold data between reads
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- hdl/qls_stack.sv -----
// ----------------------------------------------------------------------------
// qls_stack
// Range stack: pending index ranges, push and pop with registered pop data.
// ----------------------------------------------------------------------------
module qls_stack
  import qls_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_ELEMENTS_DEF / 2,
  parameter int unsigned AW    = 5,
  parameter int unsigned SPW   = 6,
  parameter int unsigned EW    = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_ctrl_t     ctrl,
  input  logic [EW-1:0] push_data,
  output logic [EW-1:0] pop_data,
  output stk_stat_t     stat
);

  logic [EW-1:0]  mem [DEPTH];
  logic [EW-1:0]  pop_data_r;
  logic [SPW-1:0] sp_r;
  logic [SPW-1:0] sp_nxt;
  logic [SPW-1:0] sp_dec;

  assign sp_dec     = sp_r - 1'b1;
  assign stat.empty = (sp_r == '0);
  assign stat.full  = (sp_r == SPW'(DEPTH));

  // Advance the stack pointer
  always_comb begin
    sp_nxt = sp_r;
    if (ctrl.push && !stat.full) begin
      sp_nxt = sp_r + 1'b1;
    end else if (ctrl.pop && !stat.empty) begin
      sp_nxt = sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  // Store pushed range, fetch top range on pop
  always_ff @(posedge clk) begin
    if (ctrl.push && !stat.full) begin
      mem[sp_r[AW-1:0]] <= push_data;
    end
    if (ctrl.pop && !stat.empty) begin
      pop_data_r <= mem[sp_dec[AW-1:0]];
    end
  end

  assign pop_data = pop_data_r;

endmodule

// ----- hdl/quicksort_lomuto_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// quicksort_lomuto_sorter_unit
// Collects a list of signed words, sorts it by quicksort with Lomuto
// partitioning and streams the sorted list out.
// ----------------------------------------------------------------------------
// Operation: the block takes one request per cycle while it collects a list.
// After the request marked last it sorts the list and accepts nothing until
// the final sorted word is registered for output. Each partition pops its
// range (S_POP), opens it and reads the pivot (S_RANGE, S_PIVOT), fetches
// and compares each scanned element (S_FETCH, S_SCAN) with S_SWAP added
// for each exchange, and pushes the sub-ranges (S_PUSH_LO, S_PUSH_HI);
// every sorted word is then read out through S_OUT_RD and S_OUT_LOAD. The
// element memory has a single write port, so an exchange needs two writes.
// An already sorted list is the worst case. Words beyond MAX_ELEMENTS are
// dropped and every result of that list carries the overflow flag.
// ----------------------------------------------------------------------------
`include "quicksort_lomuto_sorter_unit_defines.svh"

module quicksort_lomuto_sorter_unit
  import qls_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_sorted_value,
  output logic                      out_end_of_list,
  output logic                      out_overflow
);

  localparam int unsigned IDX_W     = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned STK_DEPTH = MAX_ELEMENTS / 2;
  localparam int unsigned STK_AW    = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
  localparam int unsigned SP_W      = $clog2(STK_DEPTH + 1);
  localparam int unsigned ENTRY_W   = 2 * IDX_W;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [IDX_W-1:0]          lo_r, lo_nxt;
  logic [IDX_W-1:0]          hi_r, hi_nxt;
  logic [IDX_W-1:0]          place_r, place_nxt;
  logic [IDX_W-1:0]          k_r, k_nxt;
  logic signed [VALUE_W-1:0] pivot_r, pivot_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                      out_eol_r, out_eol_nxt;
  logic                      out_ovf_r, out_ovf_nxt;
  logic                      out_load;

  mem_ctrl_t                 st_ctrl;
  logic [IDX_W-1:0]          st_waddr;
  logic signed [VALUE_W-1:0] st_wdata;
  logic [IDX_W-1:0]          st_raddr_a;
  logic [IDX_W-1:0]          st_raddr_b;
  logic signed [VALUE_W-1:0] st_rdata_a;
  logic signed [VALUE_W-1:0] st_rdata_b;

  stk_ctrl_t                 stk_ctrl;
  stk_stat_t                 stk_stat;
  logic [ENTRY_W-1:0]        stk_push_data;
  logic [ENTRY_W-1:0]        stk_pop_data;
  logic [IDX_W-1:0]          entry_lo;
  logic [IDX_W-1:0]          entry_hi;

  logic                      in_fire;
  logic                      not_greater;

  assign entry_lo = stk_pop_data[ENTRY_W-1:IDX_W];
  assign entry_hi = stk_pop_data[IDX_W-1:0];
  assign in_ready = (state_r == S_LOAD);
  assign in_fire  = in_valid && in_ready;

  // Compare unit: element against pivot
  assign not_greater = (st_rdata_a <= pivot_r);

  qls_store #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .ctrl    (st_ctrl),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (st_raddr_a),
    .raddr_b (st_raddr_b),
    .rdata_a (st_rdata_a),
    .rdata_b (st_rdata_b)
  );

  qls_stack #(
    .DEPTH (STK_DEPTH),
    .AW    (STK_AW),
    .SPW   (SP_W),
    .EW    (ENTRY_W)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (stk_ctrl),
    .push_data (stk_push_data),
    .pop_data  (stk_pop_data),
    .stat      (stk_stat)
  );

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    place_nxt     = place_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    out_load      = 1'b0;
    out_eol_nxt   = 1'b0;
    st_ctrl       = '0;
    st_waddr      = place_r;
    st_wdata      = st_rdata_a;
    st_raddr_a    = k_r;
    st_raddr_b    = place_r;
    stk_ctrl      = '0;
    stk_push_data = {lo_r, IDX_W'(place_r - 1'b1)};

    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          // Store the request or drop it when full
          if (count_r < CNT_W'(MAX_ELEMENTS)) begin
            st_ctrl.wr_en = 1'b1;
            st_waddr      = count_r[IDX_W-1:0];
            st_wdata      = in_value;
            count_nxt     = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            k_nxt = '0;
            if (count_nxt >= CNT_W'(2)) begin
              stk_ctrl.push = 1'b1;
              stk_push_data = {{IDX_W{1'b0}}, IDX_W'(count_nxt - 1'b1)};
              state_nxt     = S_POP;
            end else begin
              state_nxt = S_OUT_RD;
            end
          end
        end
      end

      S_POP: begin
        if (stk_stat.empty) begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          stk_ctrl.pop = 1'b1;
          state_nxt    = S_RANGE;
        end
      end

      S_RANGE: begin
        // Open the range and read its pivot
        lo_nxt        = entry_lo;
        hi_nxt        = entry_hi;
        place_nxt     = entry_lo;
        k_nxt         = entry_lo;
        st_ctrl.rd_en = 1'b1;
        st_raddr_a    = entry_hi;
        state_nxt     = S_PIVOT;
      end

      S_PIVOT: begin
        pivot_nxt = st_rdata_a;
        state_nxt = S_FETCH;
      end

      S_FETCH: begin
        st_ctrl.rd_en = 1'b1;
        state_nxt     = S_SCAN;
      end

      S_SCAN: begin
        // Pivot itself always passes, so the last step is the final exchange
        if (not_greater) begin
          st_ctrl.wr_en = 1'b1;
          st_waddr      = place_r;
          st_wdata      = st_rdata_a;
          state_nxt     = S_SWAP;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_FETCH;
        end
      end

      S_SWAP: begin
        st_ctrl.wr_en = 1'b1;
        st_waddr      = k_r;
        st_wdata      = st_rdata_b;
        if (k_r == hi_r) begin
          state_nxt = S_PUSH_LO;
        end else begin
          place_nxt = place_r + 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_FETCH;
        end
      end

      S_PUSH_LO: begin
        // Push the part below the pivot when it holds two or more
        if ({1'b0, place_r} > ({1'b0, lo_r} + 1'b1)) begin
          stk_ctrl.push = 1'b1;
          stk_push_data = {lo_r, IDX_W'(place_r - 1'b1)};
        end
        state_nxt = S_PUSH_HI;
      end

      S_PUSH_HI: begin
        // Push the part above the pivot when it holds two or more
        if (({1'b0, place_r} + 1'b1) < {1'b0, hi_r}) begin
          stk_ctrl.push = 1'b1;
          stk_push_data = {IDX_W'(place_r + 1'b1), hi_r};
        end
        state_nxt = S_POP;
      end

      S_OUT_RD: begin
        // Read the next word once the output register frees up
        if (!out_valid_r || out_ready) begin
          st_ctrl.rd_en = 1'b1;
          st_raddr_a    = k_r;
          state_nxt     = S_OUT_LOAD;
        end
      end

      S_OUT_LOAD: begin
        out_load    = 1'b1;
        out_eol_nxt = ((CNT_W'(k_r) + 1'b1) == count_r);
        if (out_eol_nxt) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_OUT_RD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Output register: load a word, drop it when taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = st_rdata_a;
      out_ovf_nxt   = ovf_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    place_r     <= place_nxt;
    k_r         <= k_nxt;
    pivot_r     <= pivot_nxt;
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (out_load) begin
      out_eol_r <= out_eol_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_list  = out_eol_r;
  assign out_overflow     = out_ovf_r;

  // Checks
  `QLS_ASSERT_IMPL(a_place_le_k, (state_r == S_SCAN) || (state_r == S_SWAP), place_r <= k_r)
  `QLS_ASSERT_IMPL(a_k_le_hi, (state_r == S_SCAN) || (state_r == S_SWAP), k_r <= hi_r)
  `QLS_ASSERT_IMPL(a_count_cap, state_r == S_LOAD, count_r <= CNT_W'(MAX_ELEMENTS))
  `QLS_ASSERT_IMPL(a_push_room, stk_ctrl.push, !stk_stat.full)
  `QLS_ASSERT_NEXT(a_eol_clears, out_load && out_eol_nxt, (state_r == S_LOAD) && (count_r == '0))

endmodule

// ----- verif/qls_sort_checker.sv -----
// ----------------------------------------------------------------------------
// qls_sort_checker
// Watches both channels of the quicksort sorter unit. It keeps its own copy
// of the list that is being collected. When a request marked last arrives,
// it sorts that copy by Lomuto quicksort and queues the sorted words as
// expected results. Each accepted result is then compared field by field
// with the oldest expected word.
// ----------------------------------------------------------------------------
module qls_sort_checker
  import qls_pkg::*;
#(
  parameter int unsigned CAPACITY = MAX_ELEMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [VALUE_W-1:0] out_sorted_value,
  input  logic                      out_end_of_list,
  input  logic                      out_overflow,
  output int unsigned               pending_words,
  output int unsigned               error_count
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      end_of_list;
    logic                      overflow;
  } sorted_word_t;

  // List being collected, and whether words were dropped from it
  logic signed [VALUE_W-1:0] list_store[$];
  logic                      list_dropped;

  // Sorted words still to come out of the block
  sorted_word_t              expected_words[$];

  initial begin
    pending_words = 0;
    error_count   = 0;
    list_dropped  = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] sorter mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Sort list_store in place: Lomuto partition, last word as pivot,
  // pending ranges kept on an explicit stack
  function automatic void lomuto_sort();
    int unsigned               span_lo[$];
    int unsigned               span_hi[$];
    int unsigned               lo;
    int unsigned               hi;
    int unsigned               place;
    int unsigned               k;
    logic signed [VALUE_W-1:0] pivot;
    logic signed [VALUE_W-1:0] swap_word;
    if (list_store.size() < 2) return;
    span_lo.push_back(0);
    span_hi.push_back(list_store.size() - 1);
    while (span_lo.size() != 0) begin
      lo    = span_lo.pop_back();
      hi    = span_hi.pop_back();
      pivot = list_store[hi];
      place = lo;
      for (k = lo; k < hi; k++) begin
        if (list_store[k] <= pivot) begin
          swap_word         = list_store[place];
          list_store[place] = list_store[k];
          list_store[k]     = swap_word;
          place++;
        end
      end
      // Move the pivot into its final slot
      list_store[hi]    = list_store[place];
      list_store[place] = pivot;
      if (place > lo + 1) begin
        span_lo.push_back(lo);
        span_hi.push_back(place - 1);
      end
      if (place + 1 < hi) begin
        span_lo.push_back(place + 1);
        span_hi.push_back(hi);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    sorted_word_t got;
    sorted_word_t want;
    int unsigned  k;
    if (rst_n) begin
      // Compare an accepted result with the oldest expected word
      if (out_valid && out_ready) begin
        got.value       = out_sorted_value;
        got.end_of_list = out_end_of_list;
        got.overflow    = out_overflow;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result %0d with none expected", $signed(got.value)));
        end else begin
          want = expected_words.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                      $signed(got.value), $signed(want.value)));
          if (got.end_of_list !== want.end_of_list)
            report_mismatch($sformatf("end_of_list %b, expected %b",
                                      got.end_of_list, want.end_of_list));
          if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      got.overflow, want.overflow));
        end
      end
      // Store the request, or drop it once the list is full
      if (in_valid && in_ready) begin
        if (list_store.size() < CAPACITY) begin
          list_store.push_back(in_value);
        end else begin
          list_dropped = 1'b1;
        end
        // Close the list: sort it and queue every word as a result
        if (in_last) begin
          lomuto_sort();
          for (k = 0; k < list_store.size(); k++) begin
            want.value       = list_store[k];
            want.end_of_list = (k + 1 == list_store.size());
            want.overflow    = list_dropped;
            expected_words.push_back(want);
          end
          list_store.delete();
          list_dropped = 1'b0;
        end
      end
      pending_words = expected_words.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the quicksort sorter unit. It sends lists of signed words
// with random gaps and stalls the result channel at random. Directed lists
// come first: one word, corner values with duplicates, rising, falling and
// flat lists. Random lists of mixed length and shape follow, some of them
// longer than the capacity. A separate checker predicts and compares the
// results.
// ----------------------------------------------------------------------------
module tb_top
  import qls_pkg::*;
();

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned CAP           = MAX_ELEMENTS_DEF;
  localparam int unsigned RANDOM_WORDS  = 360;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_CORNER,
    SPREAD_NARROW
  } value_spread_t;

  typedef enum int unsigned {
    SHAPE_RANDOM,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_FLAT
  } list_shape_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] in_value  = '0;
  logic                      in_last   = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_sorted_value;
  logic                      out_end_of_list;
  logic                      out_overflow;

  int unsigned               pending_words;
  int unsigned               error_count;
  int unsigned               cycle_count = 0;

  logic signed [VALUE_W-1:0] batch[$];
  bit                        sender_burst = 1'b0;
  bit                        ready_quiet  = 1'b0;
  int unsigned               quiet_left   = 0;
  int unsigned               stall_left   = 0;

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  quicksort_lomuto_sorter_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_end_of_list  (out_end_of_list),
    .out_overflow     (out_overflow)
  );

  qls_sort_checker #(
    .CAPACITY (CAP)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_end_of_list  (out_end_of_list),
    .out_overflow     (out_overflow),
    .pending_words    (pending_words),
    .error_count      (error_count)
  );

  // Stall the result channel: mostly ready, short and long stalls,
  // with quiet stretches of no stalling at all
  always @(posedge clk) begin : result_ready_gen
    int unsigned roll;
    if (quiet_left == 0) begin
      ready_quiet <= ($urandom_range(0, 3) == 0);
      quiet_left  <= $urandom_range(100, 600);
    end else begin
      quiet_left <= quiet_left - 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (ready_quiet) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= (roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_word(input logic signed [VALUE_W-1:0] word, input logic closes);
    in_valid <= 1'b1;
    in_value <= word;
    in_last  <= closes;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Drop valid for a random number of cycles, unless in a burst
  task automatic sender_gap();
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 99);
    span = 0;
    if (!sender_burst) begin
      if (roll >= 95) begin
        span = $urandom_range(8, 40);
      end else if (roll >= 65) begin
        span = $urandom_range(1, 3);
      end
    end
    if (span != 0) begin
      in_valid <= 1'b0;
      repeat (span) @(posedge clk);
    end
  endtask

  // Hold off the next request until every sorted word has come out
  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    @(posedge clk);
  endtask

  task automatic send_batch();
    int unsigned idx;
    for (idx = 0; idx < batch.size(); idx++) begin
      if (idx != 0) sender_gap();
      send_word(batch[idx], idx + 1 == batch.size());
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] draw_word(input value_spread_t spread);
    logic signed [VALUE_W-1:0] word;
    case (spread)
      SPREAD_CORNER: begin
        case ($urandom_range(0, 4))
          0:       word = 32'sh8000_0000;
          1:       word = 32'sh7FFF_FFFF;
          2:       word = '0;
          3:       word = -32'sd1;
          default: word = 32'sd1;
        endcase
      end
      SPREAD_NARROW: word = 32'($urandom_range(0, 8)) - 32'sd4;
      default:       word = $urandom;
    endcase
    return word;
  endfunction

  // Build a list of the given length with a random shape and spread
  function automatic void fill_batch(input int unsigned len);
    list_shape_t               shape;
    value_spread_t             spread;
    logic signed [VALUE_W-1:0] word;
    int unsigned               k;
    shape  = list_shape_t'($urandom_range(0, 3));
    spread = value_spread_t'($urandom_range(0, 2));
    word   = draw_word(spread);
    batch.delete();
    for (k = 0; k < len; k++) begin
      case (shape)
        SHAPE_RISING:  word = word + 32'($urandom_range(0, 1000));
        SHAPE_FALLING: word = word - 32'($urandom_range(0, 1000));
        SHAPE_FLAT:    word = word;
        default:       word = draw_word(spread);
      endcase
      batch.push_back(word);
    end
  endfunction

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned list_idx;
    int unsigned len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lists: single word, corners with duplicates, sorted,
    // reversed and flat
    batch = '{32'sh7FFF_FFFF};
    send_batch();
    batch = '{32'sd0, -32'sd1, 32'sh8000_0000, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_batch();
    batch = '{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5};
    send_batch();
    batch = '{32'sd100, 32'sd50, 32'sd0, -32'sd50, -32'sd100};
    send_batch();
    batch = '{-32'sd7, -32'sd7, -32'sd7, -32'sd7};
    send_batch();
    drain_pause();

    // Random lists; some run past the capacity so the words beyond it are dropped
    random_sent = 0;
    list_idx    = 0;
    while (random_sent < RANDOM_WORDS) begin
      if (list_idx % 16 == 2) begin
        len = $urandom_range(CAP + 1, CAP + 4);
      end else begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(33, CAP);
          1, 2:    len = $urandom_range(13, 32);
          default: len = $urandom_range(1, 12);
        endcase
      end
      sender_burst = ($urandom_range(0, 4) == 0);
      fill_batch(len);
      sender_gap();
      send_batch();
      random_sent += len;
      if ($urandom_range(0, 9) == 0) drain_pause();
      list_idx++;
    end

    // Wait for the last sorted words, then let the block settle
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
